// ===== rtl/tka_pkg.sv =====
`default_nettype none

package tka_pkg;

  localparam int MAX_CLASSES_DEF = 32;

  localparam int SCORE_W   = 32;
  localparam int LABEL_W   = 16;
  localparam int COUNT_W   = 32;
  localparam int RATIO_W   = 17;
  localparam int TOPK_W    = 6;
  localparam int CLS_OUT_W = 5;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;

  // one quotient bit per step, Q1.16 result
  localparam int DIV_STEPS  = RATIO_W;
  localparam int DIV_STEP_W = $clog2(DIV_STEPS + 1);

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TOP_K            = 2'd0,
    REG_IGNORE_ENABLE    = 2'd1,
    REG_IGNORE_LABEL     = 2'd2,
    REG_PER_CLASS_ENABLE = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic signed [SCORE_W-1:0] score;
    logic signed [LABEL_W-1:0] label;
    logic                      last_score;
    logic                      last_in_batch;
  } item_t;

  typedef struct packed {
    logic                 kind;
    logic [CLS_OUT_W-1:0] class_index;
    logic [COUNT_W-1:0]   hits;
    logic [COUNT_W-1:0]   total;
    logic [RATIO_W-1:0]   ratio;
    logic [COUNT_W-1:0]   bad_labels;
    logic                 last;
  } result_t;

  typedef struct packed {
    logic clear;
    logic step;
  } rank_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

  function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
    sat_inc = (v == COUNT_MAX) ? v : v + COUNT_W'(1);
  endfunction

endpackage

`default_nettype wire

// ===== rtl/tka_rank_unit.sv =====
`default_nettype none

module tka_rank_unit
  import tka_pkg::*;
#(
  parameter int MAX_CLASSES = MAX_CLASSES_DEF,
  localparam int CIW = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1,
  localparam int CPW = $clog2(MAX_CLASSES + 1)
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire rank_ctl_t                 ctl,
  input  wire logic signed [SCORE_W-1:0] label_score,
  input  wire logic [CIW-1:0]            label_class,
  input  wire logic signed [SCORE_W-1:0] score,
  input  wire logic [CIW-1:0]            score_class,
  output logic [CPW-1:0]                 above
);

  logic signed [SCORE_W-1:0] ref_score;
  logic [CIW-1:0]            ref_class;
  logic                      ranks_above;

  // equal scores: the higher class index ranks first
  assign ranks_above = (score_class != ref_class) &&
                       ((score > ref_score) ||
                        ((score == ref_score) && (score_class > ref_class)));

  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      ref_score <= label_score;
      ref_class <= label_class;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      above <= '0;
    end else if (ctl.step && ranks_above) begin
      above <= above + CPW'(1);
    end
  end

endmodule

`default_nettype wire

// ===== rtl/tka_ratio_div.sv =====
`default_nettype none

module tka_ratio_div
  import tka_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic [COUNT_W-1:0] hits,
  input  wire logic [COUNT_W-1:0] total,
  output div_status_t             status,
  output logic [RATIO_W-1:0]      ratio
);

  logic [COUNT_W:0]      rem;
  logic [COUNT_W-1:0]    divisor;
  logic [DIV_STEP_W-1:0] steps_left;
  logic                  busy;
  logic                  done;
  logic                  fits;
  logic [COUNT_W:0]      rem_sub;

  assign fits    = rem >= {1'b0, divisor};
  assign rem_sub = fits ? rem - {1'b0, divisor} : rem;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        // hits never exceed total, so the quotient fits in 17 bits
        busy <= (total != '0);
        done <= (total == '0);
      end else if (busy && steps_left == DIV_STEP_W'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem        <= {1'b0, hits};
      divisor    <= total;
      ratio      <= '0;
      steps_left <= DIV_STEP_W'(DIV_STEPS);
    end else if (busy) begin
      ratio      <= {ratio[RATIO_W-2:0], fits};
      rem        <= {rem_sub[COUNT_W-1:0], 1'b0};
      steps_left <= steps_left - DIV_STEP_W'(1);
    end
  end

  assign status.busy = busy;
  assign status.done = done;

endmodule

`default_nettype wire

// ===== rtl/topk_accuracy_counter.sv =====
`default_nettype none

// Top-k accuracy counter. Class scores of a position arrive one per beat in class
// order. The beat with last_score closes the position: the label's score is
// fetched from the score store and the stored classes are walked through one
// comparator, one class a cycle; the walk is skipped when the label is ignored
// or out of range, and a per-class count write follows when per-class counts
// are kept. item_ready stays low meanwhile. With last_in_batch the block then
// reports: the overall result and, when per_class_enable is set, one result per
// class. Each result waits on a shared 17-step divider for its Q1.16 ratio, and
// a result beat also waits on any output stall. All counters clear after the
// last beat.
module topk_accuracy_counter
  import tka_pkg::*;
#(
  parameter int MAX_CLASSES = MAX_CLASSES_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                  item_valid,
  output logic                       item_ready,
  input  wire item_t                 item,
  output logic                       result_valid,
  input  wire logic                  result_ready,
  output result_t                    result
);

  localparam int CIW = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1;
  localparam int CPW = $clog2(MAX_CLASSES + 1);
  localparam int AW  = (CPW > TOPK_W) ? CPW : TOPK_W;

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_CHECK  = 9'b000000010,
    S_LREAD  = 9'b000000100,
    S_WALK   = 9'b000001000,
    S_TALLY  = 9'b000010000,
    S_CWRITE = 9'b000100000,
    S_RSTART = 9'b001000000,
    S_RWAIT  = 9'b010000000,
    S_EMIT   = 9'b100000000
  } state_t;

  state_t state;

  // configuration
  logic [TOPK_W-1:0]         top_k;
  logic                      ignore_enable;
  logic signed [LABEL_W-1:0] skip_label;
  logic                      per_class_enable;

  // position tracking
  logic [CPW-1:0]            pos;
  logic [CPW-1:0]            classes;
  logic signed [LABEL_W-1:0] label_q;
  logic                      batch_q;
  logic [CPW-1:0]            walk_idx;
  logic [CIW-1:0]            cmp_cls;
  logic                      hit_q;

  // totals
  logic [COUNT_W-1:0] hit_total;
  logic [COUNT_W-1:0] counted_total;
  logic [COUNT_W-1:0] bad_total;

  // report sequencing
  logic           rpt_kind;
  logic [CIW-1:0] rpt_cls;

  // score store
  logic signed [SCORE_W-1:0] score_mem [MAX_CLASSES];
  logic signed [SCORE_W-1:0] score_rd;
  logic [CIW-1:0]            score_addr;

  // per-class counters, label count in the upper half
  logic [2*COUNT_W-1:0]   cnt_mem [MAX_CLASSES];
  logic [MAX_CLASSES-1:0] cnt_vld;
  logic [2*COUNT_W-1:0]   cnt_rd;
  logic                   cnt_rd_vld;
  logic [CIW-1:0]         cnt_addr;
  logic                   cnt_re;
  logic                   cnt_we;
  logic                   cnt_clear;
  logic [COUNT_W-1:0]     cls_labels;
  logic [COUNT_W-1:0]     cls_hits;

  logic [LABEL_W-1:0] label_u;
  logic [CIW-1:0]     lab_idx;
  logic               lab_ignored;
  logic               lab_bad;
  logic               item_fire;
  logic               emit_fire;
  logic               final_beat;
  logic               hit_now;
  logic [CPW-1:0]     pos_inc;

  rank_ctl_t          rank_ctl;
  logic [CPW-1:0]     above;

  logic               div_start;
  logic [COUNT_W-1:0] div_hits;
  logic [COUNT_W-1:0] div_total;
  div_status_t        div_st;
  logic [RATIO_W-1:0] div_ratio;

  assign cfg_ready  = 1'b1;
  assign item_ready = (state == S_IDLE);
  assign item_fire  = item_valid && item_ready;

  assign label_u     = label_q;
  assign lab_idx     = label_u[CIW-1:0];
  assign lab_ignored = ignore_enable && (label_q == skip_label);
  assign lab_bad     = label_u[LABEL_W-1] || (label_u >= LABEL_W'(classes));

  assign pos_inc = (pos < CPW'(MAX_CLASSES)) ? pos + CPW'(1) : pos;

  assign hit_now = AW'(above) < AW'(top_k);

  assign cls_labels = cnt_rd_vld ? cnt_rd[2*COUNT_W-1:COUNT_W] : '0;
  assign cls_hits   = cnt_rd_vld ? cnt_rd[COUNT_W-1:0] : '0;

  assign emit_fire  = (state == S_EMIT) && (!result_valid || result_ready);
  assign final_beat = rpt_kind ? (rpt_cls == CIW'(MAX_CLASSES - 1)) : !per_class_enable;

  assign score_addr = (state == S_CHECK) ? lab_idx : walk_idx[CIW-1:0];

  always_comb begin
    cnt_addr = lab_idx;
    if (state == S_EMIT) begin
      cnt_addr = rpt_kind ? rpt_cls + CIW'(1) : '0;
    end
  end

  assign cnt_re    = ((state == S_TALLY) && per_class_enable) || (emit_fire && !final_beat);
  assign cnt_we    = (state == S_CWRITE);
  assign cnt_clear = emit_fire && final_beat;

  assign rank_ctl.clear = (state == S_LREAD);
  assign rank_ctl.step  = (state == S_WALK);

  assign div_start = (state == S_RSTART);
  assign div_hits  = rpt_kind ? cls_hits : hit_total;
  assign div_total = rpt_kind ? cls_labels : counted_total;

  tka_rank_unit #(
    .MAX_CLASSES(MAX_CLASSES)
  ) u_rank (
    .clk        (clk),
    .rst        (rst),
    .ctl        (rank_ctl),
    .label_score(score_rd),
    .label_class(lab_idx),
    .score      (score_rd),
    .score_class(cmp_cls),
    .above      (above)
  );

  tka_ratio_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .hits  (div_hits),
    .total (div_total),
    .status(div_st),
    .ratio (div_ratio)
  );

  always_ff @(posedge clk) begin
    if (item_fire && pos < CPW'(MAX_CLASSES)) begin
      score_mem[pos[CIW-1:0]] <= item.score;
    end
    score_rd <= score_mem[score_addr];
  end

  always_ff @(posedge clk) begin
    if (cnt_we) begin
      cnt_mem[lab_idx] <= {sat_inc(cls_labels), hit_q ? sat_inc(cls_hits) : cls_hits};
    end
    if (cnt_re) begin
      cnt_rd     <= cnt_mem[cnt_addr];
      cnt_rd_vld <= cnt_vld[cnt_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cnt_clear) begin
      cnt_vld <= '0;
    end else if (cnt_we) begin
      cnt_vld[lab_idx] <= 1'b1;
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      top_k            <= TOPK_W'(1);
      ignore_enable    <= 1'b0;
      skip_label       <= '0;
      per_class_enable <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_TOP_K:            top_k            <= cfg_data[TOPK_W-1:0];
        REG_IGNORE_ENABLE:    ignore_enable    <= cfg_data[0];
        REG_IGNORE_LABEL:     skip_label       <= cfg_data;
        REG_PER_CLASS_ENABLE: per_class_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (item_fire && item.last_score) begin
      label_q <= item.label;
      batch_q <= item.last_in_batch;
    end
    if (state == S_LREAD) begin
      cmp_cls <= '0;
    end else if (state == S_WALK) begin
      cmp_cls <= walk_idx[CIW-1:0];
    end
    if (state == S_TALLY) begin
      hit_q <= hit_now;
    end
    if (emit_fire) begin
      result.kind        <= rpt_kind;
      result.class_index <= CLS_OUT_W'(rpt_cls);
      result.hits        <= div_hits;
      result.total       <= div_total;
      result.ratio       <= div_ratio;
      result.bad_labels  <= rpt_kind ? '0 : bad_total;
      result.last        <= final_beat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      pos           <= '0;
      classes       <= '0;
      walk_idx      <= '0;
      hit_total     <= '0;
      counted_total <= '0;
      bad_total     <= '0;
      rpt_kind      <= 1'b0;
      rpt_cls       <= '0;
      result_valid  <= 1'b0;
    end else begin
      if (emit_fire) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (item_fire) begin
            if (item.last_score) begin
              classes <= pos_inc;
              pos     <= '0;
              state   <= S_CHECK;
            end else begin
              pos <= pos_inc;
            end
          end
        end
        S_CHECK: begin
          rpt_kind <= 1'b0;
          rpt_cls  <= '0;
          walk_idx <= '0;
          if (lab_ignored) begin
            state <= batch_q ? S_RSTART : S_IDLE;
          end else if (lab_bad) begin
            bad_total <= sat_inc(bad_total);
            state     <= batch_q ? S_RSTART : S_IDLE;
          end else begin
            state <= S_LREAD;
          end
        end
        S_LREAD: begin
          // label score captured, class 0 read issued
          walk_idx <= CPW'(1);
          state    <= S_WALK;
        end
        S_WALK: begin
          if (walk_idx < classes) begin
            walk_idx <= walk_idx + CPW'(1);
          end else begin
            state <= S_TALLY;
          end
        end
        S_TALLY: begin
          counted_total <= sat_inc(counted_total);
          if (hit_now) begin
            hit_total <= sat_inc(hit_total);
          end
          if (per_class_enable) begin
            state <= S_CWRITE;
          end else begin
            state <= batch_q ? S_RSTART : S_IDLE;
          end
        end
        S_CWRITE: begin
          state <= batch_q ? S_RSTART : S_IDLE;
        end
        S_RSTART: begin
          state <= S_RWAIT;
        end
        S_RWAIT: begin
          if (div_st.done) begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (emit_fire) begin
            if (final_beat) begin
              hit_total     <= '0;
              counted_total <= '0;
              bad_total     <= '0;
              state         <= S_IDLE;
            end else begin
              if (rpt_kind) begin
                rpt_cls <= rpt_cls + CIW'(1);
              end
              rpt_kind <= 1'b1;
              state    <= S_RSTART;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_hits_within_total: assert property (@(posedge clk) disable iff (rst)
    hit_total <= counted_total)
    else $error("hit total exceeds counted total");

  a_div_done_when_waiting: assert property (@(posedge clk) disable iff (rst)
    div_st.done |-> state == S_RWAIT)
    else $error("divider finished outside report wait");

  a_div_busy_when_waiting: assert property (@(posedge clk) disable iff (rst)
    div_st.busy |-> state == S_RWAIT)
    else $error("divider running outside report wait");

  a_walk_in_range: assert property (@(posedge clk) disable iff (rst)
    state == S_WALK |-> walk_idx <= classes)
    else $error("class walk ran past class count");

  a_result_consistent: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.hits <= result.total) && (result.ratio <= RATIO_W'(65536)))
    else $error("result beat has inconsistent counts or ratio");

  a_report_ends_idle: assert property (@(posedge clk) disable iff (rst)
    emit_fire && final_beat |=> state == S_IDLE && cnt_vld == '0 && counted_total == '0)
    else $error("counters not cleared after final report beat");

endmodule

`default_nettype wire
